// File: hdl/absu_pkg.sv
// ----------------------------------------------------------------------------
// absu_pkg
// Shared types and constants of the aligned block sub-allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package absu_pkg;

	// default sizing of the block table and of the byte offsets
	localparam int unsigned DEF_MAX_BLOCKS = 16;
	localparam int unsigned DEF_ADDR_BITS  = 32;

	// block size used when the configured size is zero (64 MiB)
	localparam logic [31:0] FALLBACK_BLOCK_SIZE = 32'd67108864;

	// reset value of the default block size register
	localparam logic [31:0] DFLT_SIZE_RESET = 32'd67108864;

	// result status codes
	typedef enum logic [1:0] {
		ST_EXISTING = 2'd0,
		ST_NEW      = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_SCAN   = 2'd1,
		S_COMMIT = 2'd2
	} state_t;

endpackage : absu_pkg

`default_nettype wire

// File: hdl/absu_table.sv
// ----------------------------------------------------------------------------
// absu_table
// Block table memory: type, capacity and bump offset per slot, one write
// port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module absu_table
	import absu_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = DEF_MAX_BLOCKS,
	parameter int unsigned ADDR_BITS  = DEF_ADDR_BITS,
	localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [IW-1:0]        wr_addr,
	input  wire logic [4:0]           wr_type,
	input  wire logic [ADDR_BITS-1:0] wr_cap,
	input  wire logic [ADDR_BITS-1:0] wr_used,
	input  wire logic [IW-1:0]        rd_addr,
	output logic      [4:0]           rd_type_s1,
	output logic      [ADDR_BITS-1:0] rd_cap_s1,
	output logic      [ADDR_BITS-1:0] rd_used_s1
);

	logic [4:0]           type_mem [MAX_BLOCKS];
	logic [ADDR_BITS-1:0] cap_mem  [MAX_BLOCKS];
	logic [ADDR_BITS-1:0] used_mem [MAX_BLOCKS];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			type_mem[wr_addr] <= wr_type;
			cap_mem[wr_addr]  <= wr_cap;
			used_mem[wr_addr] <= wr_used;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_type_s1 <= type_mem[rd_addr];
		rd_cap_s1  <= cap_mem[rd_addr];
		rd_used_s1 <= used_mem[rd_addr];
	end

endmodule : absu_table

`default_nettype wire

// File: hdl/aligned_block_suballocator_unit.sv
// ----------------------------------------------------------------------------
// aligned_block_suballocator_unit
// Linear bump sub-allocator with power-of-two alignment over a table of
// blocks; searches newest block first, opens a new block when none fits and one is free.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  cfg      | cfg_we             | cfg_wdata (default block size)
//  in       | in_valid/in_stall  | mem_kind, req_size, align_log2
//  out      | out_valid/out_stall| status, block_index, alloc_offset,
//           |                    | new_block_size
//
//  A request holds in_stall while the table is scanned and the result is
//  committed; with an empty table it goes straight to commit, and a fit found
//  earlier in the scan ends the scan sooner.
//  The scan reads one table entry per cycle through the single memory read
//  port; the fit check is a two-stage align / add-compare pipeline behind it.
//  The result sits in an output register; a new request is taken while it
//  waits, and the commit cycle holds until the output register is free.
//  arst_n clears the block count, the sequencer and the output valid, and
//  reloads the default block size.
// ----------------------------------------------------------------------------
`default_nettype none

module aligned_block_suballocator_unit
	import absu_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = DEF_MAX_BLOCKS,
	parameter int unsigned ADDR_BITS  = DEF_ADDR_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [4:0]  mem_kind,
	input  wire logic [31:0] req_size,
	input  wire logic [4:0]  align_log2,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [3:0]       block_index,
	output logic [31:0]      alloc_offset,
	output logic [31:0]      new_block_size
);

	localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned FW = ((ADDR_BITS > 32) ? ADDR_BITS : 32) + 2;
	localparam int unsigned XW = ADDR_BITS + 32;

	// control state
	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [31:0]     dflt_q;
	logic [CW-1:0]   rd_cnt_q;
	logic [IW-1:0]   rd_ptr_q;
	logic            v_s1, v_s2;
	logic            out_valid_q;

	// request registers
	logic [4:0]           type_q;
	logic [ADDR_BITS-1:0] size_q;
	logic [4:0]           lg_q;

	// scan pipeline
	logic [IW-1:0]        slot_s1, slot_s2;
	logic                 last_s1, last_s2;
	logic [4:0]           rd_type_s1;
	logic [ADDR_BITS-1:0] rd_cap_s1, rd_used_s1;
	logic                 match_s2;
	logic [FW-1:0]        aligned_s2;
	logic [ADDR_BITS-1:0] cap_s2;

	// scan decision
	logic                 hit_q;
	logic [IW-1:0]        slot_q;
	logic [ADDR_BITS-1:0] offset_q, used_new_q, cap_q;

	// output registers
	status_t     status_q;
	logic [3:0]  index_q;
	logic [31:0] offset_out_q, nsz_q;

	// sequencer strobes
	logic accept, scan_end, issue, out_load, tbl_we;

	// datapath nets
	logic [ADDR_BITS-1:0] size_clamp, dflt_clamp, new_cap;
	logic [XW-1:0]        size_wide, dflt_wide, addr_max_wide;
	logic [31:0]          dflt_eff;
	logic [FW-1:0]        amask, used_fw, size_fw, cap_fw, sum_s2;
	logic                 fit;
	logic                 full;
	logic [CW-1:0]        cnt_m1;
	logic [IW-1:0]        wr_addr;
	logic [4:0]           wr_type;
	logic [ADDR_BITS-1:0] wr_cap, wr_used;
	logic [IW+3:0]        slot_x, count_x;
	logic [XW-1:0]        offset_x, cap_x;

	// saturate the request size and the default size to the offset range
	always_comb begin
		addr_max_wide = {32'd0, {ADDR_BITS{1'b1}}};
		size_wide     = {{ADDR_BITS{1'b0}}, req_size};
		dflt_eff      = (dflt_q == 32'd0) ? FALLBACK_BLOCK_SIZE : dflt_q;
		dflt_wide     = {{ADDR_BITS{1'b0}}, dflt_eff};
		size_clamp    = (size_wide > addr_max_wide) ? {ADDR_BITS{1'b1}}
		                                            : size_wide[ADDR_BITS-1:0];
		dflt_clamp    = (dflt_wide > addr_max_wide) ? {ADDR_BITS{1'b1}}
		                                            : dflt_wide[ADDR_BITS-1:0];
		new_cap       = (size_q > dflt_clamp) ? size_q : dflt_clamp;
	end

	// fit arithmetic, widened so that nothing wraps
	always_comb begin
		amask   = ({{(FW-1){1'b0}}, 1'b1} << lg_q) - {{(FW-1){1'b0}}, 1'b1};
		used_fw = {{(FW-ADDR_BITS){1'b0}}, rd_used_s1};
		size_fw = {{(FW-ADDR_BITS){1'b0}}, size_q};
		cap_fw  = {{(FW-ADDR_BITS){1'b0}}, cap_s2};
		sum_s2  = aligned_s2 + size_fw;
		fit     = match_s2 && (sum_s2 <= cap_fw);
	end

	assign full   = (count_q == CW'(MAX_BLOCKS));
	assign cnt_m1 = count_q - CW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (count_q == '0) ? S_COMMIT : S_SCAN;
				end
			end
			S_SCAN: begin
				if (v_s2 && (fit || last_s2)) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = (state_q != S_IDLE);
		accept   = in_valid && (state_q == S_IDLE);
		scan_end = (state_q == S_SCAN) && v_s2 && (fit || last_s2);
		issue    = (state_q == S_SCAN) && !scan_end && (rd_cnt_q != '0);
		out_load = (state_q == S_COMMIT) && (!out_valid_q || !out_stall);
		tbl_we   = out_load && (hit_q || !full);
	end

	// table write: bump offset on a hit, whole entry when opening a block
	always_comb begin
		if (hit_q) begin
			wr_addr = slot_q;
			wr_type = type_q;
			wr_cap  = cap_q;
			wr_used = used_new_q;
		end else begin
			wr_addr = count_q[IW-1:0];
			wr_type = type_q;
			wr_cap  = new_cap;
			wr_used = size_q;
		end
	end

	absu_table #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.ADDR_BITS  (ADDR_BITS)
	) u_table (
		.clk        (clk),
		.wr_en      (tbl_we),
		.wr_addr    (wr_addr),
		.wr_type    (wr_type),
		.wr_cap     (wr_cap),
		.wr_used    (wr_used),
		.rd_addr    (rd_ptr_q),
		.rd_type_s1 (rd_type_s1),
		.rd_cap_s1  (rd_cap_s1),
		.rd_used_s1 (rd_used_s1)
	);

	// state, block count and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			dflt_q  <= DFLT_SIZE_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				dflt_q <= cfg_wdata;
			end
			if (out_load && !hit_q && !full) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// scan pointer and stage valids, newest slot first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			rd_ptr_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			if (accept) begin
				rd_cnt_q <= count_q;
				rd_ptr_q <= cnt_m1[IW-1:0];
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q - CW'(1);
				rd_ptr_q <= rd_ptr_q - IW'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1 && (state_q == S_SCAN) && !scan_end;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= mem_kind;
			size_q <= size_clamp;
			lg_q   <= align_log2;
		end
	end

	// align stage
	always_ff @(posedge clk) begin
		slot_s1    <= rd_ptr_q;
		last_s1    <= (rd_cnt_q == CW'(1));
		slot_s2    <= slot_s1;
		last_s2    <= last_s1;
		match_s2   <= (rd_type_s1 == type_q);
		aligned_s2 <= (used_fw + amask) & ~amask;
		cap_s2     <= rd_cap_s1;
	end

	// scan decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (accept) begin
			hit_q <= 1'b0;
		end else if (scan_end) begin
			hit_q <= fit;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_end && fit) begin
			slot_q     <= slot_s2;
			offset_q   <= aligned_s2[ADDR_BITS-1:0];
			used_new_q <= sum_s2[ADDR_BITS-1:0];
			cap_q      <= cap_s2;
		end
	end

	// result fields narrowed to port widths
	always_comb begin
		slot_x   = {4'd0, slot_q};
		count_x  = {4'd0, count_q[IW-1:0]};
		offset_x = {32'd0, offset_q};
		cap_x    = {32'd0, new_cap};
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (hit_q) begin
				status_q     <= ST_EXISTING;
				index_q      <= slot_x[3:0];
				offset_out_q <= offset_x[31:0];
				nsz_q        <= 32'd0;
			end else if (full) begin
				status_q     <= ST_FULL;
				index_q      <= 4'd0;
				offset_out_q <= 32'd0;
				nsz_q        <= 32'd0;
			end else begin
				status_q     <= ST_NEW;
				index_q      <= count_x[3:0];
				offset_out_q <= 32'd0;
				nsz_q        <= cap_x[31:0];
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign block_index    = index_q;
	assign alloc_offset   = offset_out_q;
	assign new_block_size = nsz_q;

endmodule : aligned_block_suballocator_unit

`default_nettype wire

// File: hdl/absu_checker.sv
// ----------------------------------------------------------------------------
// absu_checker
// Port-level checks of the sub-allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module absu_checker
	import absu_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  status,
	input wire logic [3:0]  block_index,
	input wire logic [31:0] alloc_offset,
	input wire logic [31:0] new_block_size
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// an accepted request keeps the block busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted without going busy");

	// an out-of-blocks result carries zero fields
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |->
		(block_index == 4'd0) && (alloc_offset == 32'd0) && (new_block_size == 32'd0))
		else $error("out-of-blocks result with nonzero fields");

	// placement in an existing block reports no new block
	a_existing_nsz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EXISTING) |-> (new_block_size == 32'd0))
		else $error("existing-block result with a block size");

	// a new block always starts its allocation at offset zero
	a_new_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NEW) |-> (alloc_offset == 32'd0))
		else $error("new-block result with nonzero offset");

endmodule : absu_checker

bind aligned_block_suballocator_unit absu_checker u_absu_checker (.*);

`default_nettype wire
